// File: design/ckt_pkg.sv
package ckt_pkg;

    typedef enum logic [1:0] {
        MODE_IDLE = 2'd0,
        MODE_WORD = 2'd1,
        MODE_NUM  = 2'd2,
        MODE_DOT  = 2'd3
    } t_mode;

    localparam logic [5:0] KIND_END    = 6'd0;
    localparam logic [5:0] KIND_IDENT  = 6'd34;
    localparam logic [5:0] KIND_NUMBER = 6'd35;

    localparam logic CFG_START_POSITION = 1'b0;
    localparam logic CFG_START_COLUMN   = 1'b1;

    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_UNDER = 8'h5F;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_LO_E  = 8'h65;
    localparam logic [7:0] CH_UP_E  = 8'h45;
    localparam logic [7:0] CH_LO_P  = 8'h70;
    localparam logic [7:0] CH_UP_P  = 8'h50;

    localparam int KW_COUNT = 33;

    // Keywords in alphabetical order, written first character in the highest used byte.
    localparam logic [63:0] KW_TEXT [KW_COUNT] = '{
        "auto", "break", "case", "char", "const", "continue", "default", "do",
        "double", "else", "enum", "extern", "float", "for", "goto", "if",
        "inline", "int", "long", "register", "return", "short", "signed",
        "sizeof", "static", "struct", "switch", "typedef", "union", "unsigned",
        "void", "volatile", "while"
    };

    typedef struct packed {
        logic [5:0]  kind;
        logic [31:0] offset;
        logic [31:0] col;
        logic [7:0]  length;
        logic        too_long;
        logic        last;
    } t_result;

    // Up to two results per byte; second one only ever follows the first.
    typedef struct packed {
        logic    v0;
        logic    v1;
        t_result r0;
        t_result r1;
    } t_push;

    function automatic logic is_alpha(input logic [7:0] b);
        return (b >= 8'h61 && b <= 8'h7A) || (b >= 8'h41 && b <= 8'h5A);
    endfunction

    function automatic logic is_digit(input logic [7:0] b);
        return b >= 8'h30 && b <= 8'h39;
    endfunction

    function automatic logic [3:0] kw_len(input logic [63:0] be);
        logic [3:0] n;
        n = 4'd0;
        for (int i = 0; i < 8; i++) begin
            if (be[8*i +: 8] != 8'h00) begin
                n = n + 4'd1;
            end
        end
        return n;
    endfunction

    // Reorder so that the first character lands in the low byte.
    function automatic logic [63:0] le_pack(input logic [63:0] be, input logic [3:0] len);
        logic [63:0] res;
        res = '0;
        for (int i = 0; i < 8; i++) begin
            if (4'(i) < len) begin
                res[8*i +: 8] = be[8*(int'(len) - 1 - i) +: 8];
            end
        end
        return res;
    endfunction

    function automatic logic [5:0] keyword_kind(input logic [63:0] head,
                                                input logic [7:0]  count,
                                                input logic        over);
        logic [5:0] kind;
        logic [3:0] len;
        kind = KIND_IDENT;
        for (int k = KW_COUNT - 1; k >= 0; k--) begin
            len = kw_len(KW_TEXT[k]);
            if (!over && count == {4'd0, len} && head == le_pack(KW_TEXT[k], len)) begin
                kind = 6'(k + 1);
            end
        end
        return kind;
    endfunction

endpackage

// File: design/ckt_scan.sv
module ckt_scan #(
    parameter int MAX_TOKEN_LEN = 255
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    input  logic [7:0]    i_byte,
    input  logic          i_cfg_we,
    input  logic          i_cfg_index,
    input  logic [31:0]   i_cfg_data,
    output ckt_pkg::t_push o_push
);
    import ckt_pkg::*;

    localparam int CNT_W = $clog2(MAX_TOKEN_LEN + 1);

    t_mode              r_mode, n_mode;
    logic [63:0]        r_head, n_head;
    logic [CNT_W-1:0]   r_count, n_count;
    logic               r_over, n_over;
    logic               r_exp, n_exp;
    logic [31:0]        r_tok_off, n_tok_off;
    logic [31:0]        r_tok_col, n_tok_col;
    logic [31:0]        r_cur_off, n_cur_off;
    logic [31:0]        r_cur_col, n_cur_col;
    logic               r_fin, n_fin;

    logic               used, take, open_tok, emit_tok, emit_end;
    logic [5:0]         tok_kind;
    logic [63:0]        base_head;
    logic [CNT_W-1:0]   base_count;
    logic               base_over;
    t_result            tok_res, end_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode    <= MODE_IDLE;
            r_count   <= '0;
            r_fin     <= 1'b0;
            r_cur_off <= '0;
            r_cur_col <= '0;
        end else begin
            r_mode    <= n_mode;
            r_count   <= n_count;
            r_fin     <= n_fin;
            r_cur_off <= n_cur_off;
            r_cur_col <= n_cur_col;
        end
    end

    always_ff @(posedge i_clk) begin
        r_head    <= n_head;
        r_over    <= n_over;
        r_exp     <= n_exp;
        r_tok_off <= n_tok_off;
        r_tok_col <= n_tok_col;
    end

    always_comb begin
        n_mode    = r_mode;
        n_exp     = r_exp;
        n_fin     = r_fin;
        n_tok_off = r_tok_off;
        n_tok_col = r_tok_col;
        n_cur_off = r_cur_off;
        n_cur_col = r_cur_col;
        used      = 1'b0;
        take      = 1'b0;
        open_tok  = 1'b0;
        emit_tok  = 1'b0;
        emit_end  = 1'b0;
        tok_kind  = KIND_NUMBER;

        if (i_valid && !r_fin) begin
            unique case (r_mode)
                MODE_WORD: begin
                    if (is_alpha(i_byte) || is_digit(i_byte) || i_byte == CH_UNDER) begin
                        take = 1'b1;
                        used = 1'b1;
                    end else begin
                        emit_tok = 1'b1;
                        tok_kind = keyword_kind(r_head, 8'(r_count), r_over);
                        n_mode   = MODE_IDLE;
                    end
                end
                MODE_NUM: begin
                    priority if (is_digit(i_byte) || i_byte == CH_DOT || i_byte == CH_UNDER) begin
                        take  = 1'b1;
                        used  = 1'b1;
                        n_exp = 1'b0;
                    end else if (is_alpha(i_byte)) begin
                        take  = 1'b1;
                        used  = 1'b1;
                        n_exp = i_byte == CH_LO_E || i_byte == CH_UP_E
                             || i_byte == CH_LO_P || i_byte == CH_UP_P;
                    end else if (r_exp && (i_byte == CH_PLUS || i_byte == CH_MINUS)) begin
                        take  = 1'b1;
                        used  = 1'b1;
                        n_exp = 1'b0;
                    end else begin
                        emit_tok = 1'b1;
                        n_mode   = MODE_IDLE;
                    end
                end
                MODE_DOT: begin
                    // drop a lone dot unless a digit follows
                    if (is_digit(i_byte)) begin
                        n_mode = MODE_NUM;
                        take   = 1'b1;
                        used   = 1'b1;
                        n_exp  = 1'b0;
                    end else begin
                        n_mode = MODE_IDLE;
                    end
                end
                MODE_IDLE: begin
                end
            endcase

            if (!used) begin
                priority if (i_byte == CH_NUL) begin
                    emit_end = 1'b1;
                    n_fin    = 1'b1;
                end else if (is_alpha(i_byte) || i_byte == CH_UNDER) begin
                    open_tok = 1'b1;
                    n_mode   = MODE_WORD;
                end else if (is_digit(i_byte)) begin
                    open_tok = 1'b1;
                    n_mode   = MODE_NUM;
                end else if (i_byte == CH_DOT) begin
                    open_tok = 1'b1;
                    n_mode   = MODE_DOT;
                end else begin
                    // skip any other byte
                end
            end

            if (open_tok) begin
                take      = 1'b1;
                n_exp     = 1'b0;
                n_tok_off = r_cur_off;
                n_tok_col = r_cur_col;
            end

            // cursors freeze on the end byte
            if (!emit_end) begin
                n_cur_off = r_cur_off + 32'd1;
                n_cur_col = r_cur_col + 32'd1;
            end
        end

        if (i_cfg_we) begin
            if (i_cfg_index == CFG_START_POSITION) begin
                n_cur_off = i_cfg_data;
            end
            if (i_cfg_index == CFG_START_COLUMN) begin
                n_cur_col = i_cfg_data;
            end
        end
    end

    // Append one byte to the token, starting afresh when a token opens.
    always_comb begin
        base_head  = open_tok ? '0 : r_head;
        base_count = open_tok ? '0 : r_count;
        base_over  = open_tok ? 1'b0 : r_over;
        n_head     = r_head;
        n_count    = r_count;
        n_over     = r_over;
        if (take) begin
            n_head  = base_head;
            n_count = base_count;
            n_over  = base_over;
            for (int i = 0; i < 8; i++) begin
                if (base_count == CNT_W'(i)) begin
                    n_head[8*i +: 8] = i_byte;
                end
            end
            if (base_count < CNT_W'(MAX_TOKEN_LEN)) begin
                n_count = base_count + CNT_W'(1);
            end else begin
                n_over = 1'b1;
            end
        end
    end

    always_comb begin
        tok_res.kind     = tok_kind;
        tok_res.offset   = r_tok_off;
        tok_res.col      = r_tok_col;
        tok_res.length   = 8'(r_count);
        tok_res.too_long = r_over;
        tok_res.last     = !emit_end;

        end_res.kind     = KIND_END;
        end_res.offset   = r_cur_off;
        end_res.col      = r_cur_col;
        end_res.length   = 8'd0;
        end_res.too_long = 1'b0;
        end_res.last     = 1'b1;

        o_push.v0 = emit_tok || emit_end;
        o_push.v1 = emit_tok && emit_end;
        o_push.r0 = emit_tok ? tok_res : end_res;
        o_push.r1 = end_res;
    end

    a_fin_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fin |=> r_fin)
        else $error("end-of-text flag dropped without reset");

    a_quiet_after_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fin |-> !o_push.v0)
        else $error("result produced after end of text");

    a_empty_is_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count == '0 |-> r_mode == MODE_IDLE)
        else $error("token open with no bytes");

endmodule

// File: design/ckt_out_queue.sv
module ckt_out_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  ckt_pkg::t_push   i_push,
    input  logic             i_pop,
    output logic             o_room,
    output logic             o_valid,
    output ckt_pkg::t_result o_head
);
    import ckt_pkg::*;

    localparam int DEPTH = 4;
    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_result            r_q [DEPTH];
    logic [PTR_W-1:0]   r_wp, n_wp;
    logic [PTR_W-1:0]   r_rp, n_rp;
    logic [CNT_W-1:0]   r_count, n_count;
    logic               do_pop;

    assign do_pop  = i_pop && r_count != '0;
    assign o_valid = r_count != '0;
    assign o_head  = r_q[r_rp];
    // room for the worst case of two results from one byte
    assign o_room  = r_count <= CNT_W'(DEPTH - 2);

    always_comb begin
        n_wp    = r_wp + PTR_W'(i_push.v0) + PTR_W'(i_push.v1);
        n_rp    = r_rp + PTR_W'(do_pop);
        n_count = r_count + CNT_W'(i_push.v0) + CNT_W'(i_push.v1) - CNT_W'(do_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= '0;
            r_rp    <= '0;
            r_count <= '0;
        end else begin
            r_wp    <= n_wp;
            r_rp    <= n_rp;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push.v0) begin
            r_q[r_wp] <= i_push.r0;
        end
        if (i_push.v1) begin
            r_q[r_wp + PTR_W'(1)] <= i_push.r1;
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(DEPTH))
        else $error("queue count past depth");

    a_push_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push.v1 |-> i_push.v0)
        else $error("second result pushed without first");

    a_push_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push.v0 |-> r_count <= CNT_W'(DEPTH - 2))
        else $error("push into queue without room");

endmodule

// File: design/c_keyword_tokenizer.sv
// channel   dir  tdata fields (low bit up)                           tlast
// s (in)    in   char_byte[7:0]                                      -
// m (out)   out  token_kind[5:0] start_offset[37:6] start_col[69:38] last
//                token_length[77:70] too_long[78] zero[79]
// cfg       in   i_cfg_index 0 start_position, 1 start_column; i_cfg_data
//
// One byte is taken per cycle; a result reaches the output queue the cycle
// after its byte and leaves as soon as the sink takes it.
// A zero byte that closes a token gives two beats; the four-entry output
// queue absorbs them, and input is held while fewer than two slots are free.
// Synchronous active-low reset clears the scanner and cursors to zero.
// After the end token, bytes are taken and dropped until reset.
module c_keyword_tokenizer #(
    parameter int MAX_TOKEN_LEN = 255
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [7:0]  i_s_tdata,   // char_byte
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [79:0] o_m_tdata,   // token_kind, start_offset, start_col,
                                     // token_length, too_long, zero pad
    output logic        o_m_tlast,
    input  logic        i_cfg_we,
    input  logic        i_cfg_index,
    input  logic [31:0] i_cfg_data
);
    import ckt_pkg::*;

    t_push   push;
    t_result head;
    logic    room;

    assign o_s_tready = room;

    ckt_scan #(
        .MAX_TOKEN_LEN(MAX_TOKEN_LEN)
    ) u_scan (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_s_tvalid && room),
        .i_byte      (i_s_tdata),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_push      (push)
    );

    ckt_out_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_pop   (i_m_tready),
        .o_room  (room),
        .o_valid (o_m_tvalid),
        .o_head  (head)
    );

    assign o_m_tdata = {1'b0, head.too_long, head.length, head.col, head.offset, head.kind};
    assign o_m_tlast = head.last;

endmodule
